>>> design/bgpm_pkg.sv
// Shared types and constants for the Bayer green peak meter.
// No dependencies; every other design file imports this package.
package bgpm_pkg;

    localparam int PIX_W          = 10;       // width of the pixel_value field
    localparam int LEVEL_W        = 10;       // width of the peak_level field
    localparam int USED_W         = 24;       // width of the pixels_used field
    localparam int TOP_W          = 24;       // width of the top_count register
    localparam int PIXEL_BITS_DEF = 10;
    localparam int COUNT_BITS_DEF = 24;
    localparam int QUEUE_DEPTH    = 4;        // power of two

    localparam logic [TOP_W-1:0] TOP_RESET = 24'd207360;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             end_of_line;
        logic             end_of_frame;
    } t_pixel_in;

    typedef struct packed {
        logic [LEVEL_W-1:0] peak_level;
        logic [USED_W-1:0]  pixels_used;
        logic               no_pixels;
    } t_peak_out;

    // One queued job for the back end.
    typedef struct packed {
        logic [PIX_W-1:0] level;
        logic             green;
        logic             eof;
    } t_bgpm_entry;

    // Control and status from the back end to the front end.
    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_ctl;

endpackage

>>> design/bgpm_front.sv
// Front end of the peak meter: accepts pixels, tracks the Bayer phase and
// queues green pixels and frame ends for the back end. Depends on bgpm_pkg.
module bgpm_front
    import bgpm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_pix_valid,
    output logic        o_pix_ready,
    input  t_pixel_in   i_pixel,
    input  t_back_ctl   i_ctl,
    output logic        o_q_valid,
    output t_bgpm_entry o_q_entry
);

    localparam int QAW = $clog2(QUEUE_DEPTH);

    t_bgpm_entry        r_q [QUEUE_DEPTH];
    logic [QAW-1:0]     r_wr_ptr;
    logic [QAW-1:0]     r_rd_ptr;
    logic [QAW:0]       r_count;
    logic               r_row_odd;
    logic               r_col_odd;

    logic accept;
    logic push;
    logic pop;
    logic green;

    assign green       = r_row_odd ^ r_col_odd;
    assign o_pix_ready = (r_count != (QAW+1)'(QUEUE_DEPTH)) && !i_ctl.clearing;
    assign accept      = i_pix_valid && o_pix_ready;
    // Pixels that are neither green nor a frame end leave no work behind.
    assign push        = accept && (green || i_pixel.end_of_frame);
    assign pop         = i_ctl.pop;
    assign o_q_valid   = (r_count != '0);
    assign o_q_entry   = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_odd <= 1'b0;
            r_col_odd <= 1'b0;
        end else if (accept) begin
            if (i_pixel.end_of_frame) begin
                r_row_odd <= 1'b0;
                r_col_odd <= 1'b0;
            end else if (i_pixel.end_of_line) begin
                r_row_odd <= !r_row_odd;
                r_col_odd <= 1'b0;
            end else begin
                r_col_odd <= !r_col_odd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= '{level: i_pixel.pixel_value, green: green,
                               eof: i_pixel.end_of_frame};
        end
    end

endmodule

>>> design/bgpm_div.sv
// Restoring divider for the peak meter, one quotient bit per cycle.
// Depends on bgpm_pkg for nothing but house consistency of parameters.
module bgpm_div
    import bgpm_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [COUNT_BITS+2*PIXEL_BITS-1:0] i_dividend,
    input  logic [COUNT_BITS+PIXEL_BITS-1:0]   i_divisor,
    output logic                             o_done,
    output logic [PIXEL_BITS-1:0]            o_quotient
);

    localparam int DW = COUNT_BITS + 2 * PIXEL_BITS;
    localparam int CW = $clog2(PIXEL_BITS + 1);

    logic [DW-1:0]         r_rem;
    logic [DW-1:0]         r_div;
    logic [PIXEL_BITS-1:0] r_quo;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic                  fits;

    // The quotient is known to fit in PIXEL_BITS, so the first trial
    // subtracts the divisor shifted up by PIXEL_BITS-1.
    assign fits       = (r_rem >= r_div);
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(PIXEL_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_div <= DW'(i_divisor) << (PIXEL_BITS - 1);
            r_quo <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - r_div;
            end
            r_quo <= {r_quo[PIXEL_BITS-2:0], fits};
            r_div <= r_div >> 1;
        end
    end

endmodule

>>> design/bgpm_back.sv
// Back end of the peak meter: histogram memory, frame-end walk, mean and
// the result register. Depends on bgpm_pkg and bgpm_div.
module bgpm_back
    import bgpm_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [TOP_W-1:0] i_top_count,
    input  logic             i_q_valid,
    input  t_bgpm_entry      i_q_entry,
    output t_back_ctl        o_ctl,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output t_peak_out        o_res
);

    localparam int NBINS = 1 << PIXEL_BITS;
    localparam int TW    = COUNT_BITS + PIXEL_BITS;
    localparam int DW    = COUNT_BITS + 2 * PIXEL_BITS;
    localparam int SAT_W = (COUNT_BITS < USED_W) ? COUNT_BITS : USED_W;

    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_INC   = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    logic [COUNT_BITS-1:0] r_hist [NBINS];

    logic [2:0]            r_state, n_state;
    logic [PIXEL_BITS-1:0] r_bin, n_bin;
    logic                  r_eof, n_eof;
    logic                  r_rd_vld, n_rd_vld;
    logic [COUNT_BITS-1:0] r_rd_data;
    logic [PIXEL_BITS-1:0] r_rd_bin;
    logic [TW-1:0]         r_prod;
    logic [COUNT_BITS-1:0] r_p_cnt;
    logic                  r_p_vld;
    logic [TW-1:0]         r_total;
    logic [DW-1:0]         r_wsum;
    logic                  r_stop;
    logic                  r_out_vld;
    t_peak_out             r_out;

    logic [PIX_W+PIXEL_BITS-1:0] lvl_ext;
    logic [PIXEL_BITS-1:0]       entry_bin;
    logic [PIXEL_BITS-1:0]       rd_addr;
    logic [PIXEL_BITS-1:0]       wr_addr;
    logic [COUNT_BITS-1:0]       wr_data;
    logic [COUNT_BITS-1:0]       inc_val;
    logic                        mem_we;
    logic                        pop;
    logic                        inc_we;
    logic                        clr_we;
    logic                        walk_init;
    logic                        div_start;
    logic                        div_done;
    logic [PIXEL_BITS-1:0]       quotient;
    logic                        out_load;
    logic [TW-1:0]               sum_total;
    logic                        no_pix;
    logic [SAT_W-1:0]            used_sat;

    assign lvl_ext   = {{PIXEL_BITS{1'b0}}, i_q_entry.level};
    assign entry_bin = lvl_ext[PIXEL_BITS-1:0];
    assign inc_val   = (&r_rd_data) ? r_rd_data : r_rd_data + COUNT_BITS'(1);

    always_comb begin
        n_state   = r_state;
        n_bin     = r_bin;
        n_eof     = r_eof;
        n_rd_vld  = 1'b0;
        rd_addr   = r_bin;
        pop       = 1'b0;
        inc_we    = 1'b0;
        clr_we    = 1'b0;
        walk_init = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_CLR: begin
                clr_we = 1'b1;
                if (r_bin == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_bin = r_bin - 1'b1;
                end
            end
            ST_IDLE: begin
                rd_addr = entry_bin;
                if (i_q_valid) begin
                    pop   = 1'b1;
                    n_eof = i_q_entry.eof;
                    if (i_q_entry.green) begin
                        n_state = ST_INC;
                    end else if (i_q_entry.eof) begin
                        walk_init = 1'b1;
                        n_state   = ST_WALK;
                    end
                end
            end
            ST_INC: begin
                inc_we = 1'b1;
                if (r_eof) begin
                    walk_init = 1'b1;
                    n_state   = ST_WALK;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_WALK: begin
                n_rd_vld = 1'b1;
                if (r_bin == '0) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_bin = r_bin - 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_vld && !r_p_vld) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_vld || i_res_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (walk_init) begin
            n_bin = '1;
        end
    end

    // Each bin read by the walk is zeroed in the cycle after its read, so the histogram
    // is clean again by the time the walk ends.
    assign mem_we  = r_rd_vld || inc_we || clr_we;
    assign wr_addr = clr_we ? r_bin : r_rd_bin;
    assign wr_data = inc_we ? inc_val : '0;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_hist[wr_addr] <= wr_data;
        end
        r_rd_data <= r_hist[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_bin     <= '1;
            r_eof     <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_p_vld   <= 1'b0;
            r_stop    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_bin    <= n_bin;
            r_eof    <= n_eof;
            r_rd_vld <= n_rd_vld;
            r_p_vld  <= r_rd_vld;
            if (walk_init) begin
                r_stop <= 1'b0;
            end else if (r_p_vld && !r_stop) begin
                r_stop <= (sum_total > TW'(i_top_count));
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_res_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign sum_total = r_total + TW'(r_p_cnt);

    always_ff @(posedge i_clk) begin
        r_rd_bin <= rd_addr;
        r_prod   <= TW'(r_rd_data) * TW'(r_rd_bin);
        r_p_cnt  <= r_rd_data;
        if (walk_init) begin
            r_total <= '0;
            r_wsum  <= '0;
        end else if (r_p_vld && !r_stop) begin
            r_total <= sum_total;
            r_wsum  <= r_wsum + DW'(r_prod);
        end
    end

    bgpm_div #(
        .PIXEL_BITS (PIXEL_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_wsum),
        .i_divisor  (r_total),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign no_pix   = (r_total == '0);
    assign used_sat = ((r_total >> SAT_W) != '0) ? '1 : r_total[SAT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.peak_level  <= no_pix ? '0 : LEVEL_W'(quotient);
            r_out.pixels_used <= USED_W'(used_sat);
            r_out.no_pixels   <= no_pix;
        end
    end

    assign o_ctl.pop      = pop;
    assign o_ctl.clearing = (r_state == ST_CLR);
    assign o_res_valid    = r_out_vld;
    assign o_res          = r_out;

endmodule

>>> design/bayer_green_peak_meter.sv
// Top level of the Bayer green peak meter: configuration register, front
// end, back end and assertions. Depends on bgpm_pkg, bgpm_front, bgpm_back.
//
//   Channel  Handshake                    Payload
//   pixels   i_pix_valid / o_pix_ready    i_pixel (t_pixel_in)
//   results  o_res_valid / i_res_ready    o_res   (t_peak_out)
//   config   i_cfg_we, no wait            i_cfg_data (top_count)
//
// The front end takes one pixel per cycle while its four-entry queue has
// room; pixels that are not green and do not end the frame are dropped there.
// Each queued green pixel costs the back end a read and then a write of
// its bin, because the histogram memory has one read and one write.
// A frame end costs a walk over every bin, a divide and the load of the
// result. After reset the histogram is cleared bin by bin, and no pixel
// is accepted until the clear is done. A result waiting in its register
// blocks only the back end; the front end keeps filling its queue.
module bayer_green_peak_meter
    import bgpm_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_pix_valid,
    output logic             o_pix_ready,
    input  t_pixel_in        i_pixel,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output t_peak_out        o_res,
    input  logic             i_cfg_we,
    input  logic [TOP_W-1:0] i_cfg_data
);

    logic [TOP_W-1:0] r_top_count;
    logic             q_valid;
    t_bgpm_entry      q_entry;
    t_back_ctl        back_ctl;

    // The walk threshold; the user must write it only while the block is idle, as the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_count <= TOP_RESET;
        end else if (i_cfg_we) begin
            r_top_count <= i_cfg_data;
        end
    end

    bgpm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_pix_valid),
        .o_pix_ready (o_pix_ready),
        .i_pixel     (i_pixel),
        .i_ctl       (back_ctl),
        .o_q_valid   (q_valid),
        .o_q_entry   (q_entry)
    );

    bgpm_back #(
        .PIXEL_BITS (PIXEL_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_top_count (r_top_count),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_entry),
        .o_ctl       (back_ctl),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

`ifndef ASSERT_OFF
    // No pixel may enter while the histogram is still being cleared.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_ctl.clearing |-> !o_pix_ready)
        else $error("pixel ready during histogram clear");

    // The back end only pops an entry that the queue actually holds.
    a_pop_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_ctl.pop |-> q_valid)
        else $error("queue popped while empty");

    // An empty frame reports a zero level and a zero count.
    a_empty_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.no_pixels) |->
            (o_res.peak_level == '0 && o_res.pixels_used == '0))
        else $error("empty frame with nonzero result");

    // A frame with green pixels always counts at least one of them.
    a_used_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.no_pixels) |-> (o_res.pixels_used != '0))
        else $error("nonempty frame reports zero pixels");
`endif

endmodule
